// ===== sv/spkrm_pkg.sv =====
// ----------------------------------------------------------------------------
// spkrm_pkg
// Types and constants shared by the spike removal glyph map unit.
// ----------------------------------------------------------------------------
package spkrm_pkg;

   localparam int unsigned LevelW   = 4;
   localparam int unsigned GlyphW   = 7;
   localparam int unsigned ColsW    = 7;
   localparam int unsigned SumW     = 6;
   localparam int unsigned CntW     = 3;

   localparam logic [LevelW-1:0] TopLevel    = 4'd9;
   localparam logic [ColsW-1:0]  ColsReset   = 7'd30;

   localparam logic OpPixel = 1'b0;
   localparam logic OpDrain = 1'b1;

   typedef logic [LevelW-1:0] level_type;

   typedef struct packed {
      level_type centre;
      level_type right;
      level_type down;
      level_type left;
      level_type up;
      logic      has_right;
      logic      has_down;
      logic      has_left;
      logic      has_up;
   } spkrm_nbr_type;

   function automatic logic [GlyphW-1:0] glyph_of(input level_type level);
      logic [GlyphW-1:0] code;
      case (level)
         4'd0:    code = 7'd32;
         4'd1:    code = 7'd46;
         4'd2:    code = 7'd39;
         4'd3:    code = 7'd58;
         4'd4:    code = 7'd126;
         4'd5:    code = 7'd42;
         4'd6:    code = 7'd61;
         4'd7:    code = 7'd38;
         4'd8:    code = 7'd37;
         default: code = 7'd35;
      endcase
      return code;
   endfunction

endpackage

// ===== sv/spkrm_line_store.sv =====
// ----------------------------------------------------------------------------
// spkrm_line_store
// Raw and cleaned line memories, one write and one registered read port each.
// ----------------------------------------------------------------------------
module spkrm_line_store #(
   parameter int unsigned MaxColumns = 64
) (
   input  logic                            clock,
   input  logic                            raw_we,
   input  logic [$clog2(MaxColumns)-1:0]   raw_waddr,
   input  spkrm_pkg::level_type            raw_wdata,
   input  logic [$clog2(MaxColumns)-1:0]   raw_raddr,
   output spkrm_pkg::level_type            raw_rdata,
   input  logic                            cln_we,
   input  logic [$clog2(MaxColumns)-1:0]   cln_addr,
   input  spkrm_pkg::level_type            cln_wdata,
   output spkrm_pkg::level_type            cln_rdata
);
   import spkrm_pkg::*;

   level_type raw_mem [MaxColumns];
   level_type cln_mem [MaxColumns];
   level_type raw_rdata_ff;
   level_type cln_rdata_ff;

   always_ff @(posedge clock) begin
      if (raw_we) begin
         raw_mem[raw_waddr] <= raw_wdata;
      end
      raw_rdata_ff <= raw_mem[raw_raddr];
   end

   always_ff @(posedge clock) begin
      if (cln_we) begin
         cln_mem[cln_addr] <= cln_wdata;
      end
      cln_rdata_ff <= cln_mem[cln_addr];
   end

   assign raw_rdata = raw_rdata_ff;
   assign cln_rdata = cln_rdata_ff;

endmodule

// ===== sv/spkrm_clean_calc.sv =====
// ----------------------------------------------------------------------------
// spkrm_clean_calc
// Spike test against the present neighbours and rounded neighbour mean.
// ----------------------------------------------------------------------------
module spkrm_clean_calc (
   input  spkrm_pkg::spkrm_nbr_type nbr,
   output spkrm_pkg::level_type     level
);
   import spkrm_pkg::*;

   logic [CntW-1:0]   n;
   logic [SumW-1:0]   sum;
   logic              spike;
   logic [SumW:0]     x3;
   logic [SumW+6:0]   prod3;
   level_type         mean;

   always_comb begin
      n     = '0;
      sum   = '0;
      spike = 1'b1;
      if (nbr.has_right) begin
         n   = n + 1'b1;
         sum = sum + SumW'(nbr.right);
         if ({1'b0, nbr.centre} < {1'b0, nbr.right} + 5'd2) spike = 1'b0;
      end
      if (nbr.has_down) begin
         n   = n + 1'b1;
         sum = sum + SumW'(nbr.down);
         if ({1'b0, nbr.centre} < {1'b0, nbr.down} + 5'd2) spike = 1'b0;
      end
      if (nbr.has_left) begin
         n   = n + 1'b1;
         sum = sum + SumW'(nbr.left);
         if ({1'b0, nbr.centre} < {1'b0, nbr.left} + 5'd2) spike = 1'b0;
      end
      if (nbr.has_up) begin
         n   = n + 1'b1;
         sum = sum + SumW'(nbr.up);
         if ({1'b0, nbr.centre} < {1'b0, nbr.up} + 5'd2) spike = 1'b0;
      end
   end

   // divide by six as multiply by 43 and shift by 8
   assign x3    = {sum, 1'b0} + (SumW+1)'(3);
   assign prod3 = (SumW+7)'(x3) * (SumW+7)'(43);

   always_comb begin
      case (n)
         3'd1:    mean = LevelW'(sum);
         3'd2:    mean = LevelW'((sum + 1'b1) >> 1);
         3'd3:    mean = LevelW'(prod3 >> 8);
         3'd4:    mean = LevelW'((sum + 2'd2) >> 2);
         default: mean = nbr.centre;
      endcase
   end

   assign level = (n != '0 && spike) ? mean : nbr.centre;

endmodule

// ===== sv/spike_removal_glyph_map_unit.sv =====
// ----------------------------------------------------------------------------
// spike_removal_glyph_map_unit
// Four-neighbour spike removal over a raster stream, emitted one row late
// with the glyph code of each cleaned level.
// ----------------------------------------------------------------------------
// Sequence: a request that yields a result passes the states idle (line memory
// read of the centre and up entries), read (read of the right entry) and calc
// (clean and write back, held while rsp is stalled), and is then shown on rsp
// from a register. A first-row request or an ignored drain does not leave idle.
// Reset: synchronous, clears counters and flags but sets the top-row flag, and sets 30 columns; line
// memories are not cleared.
module spike_removal_glyph_map_unit #(
   parameter int unsigned MaxColumns = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [3:0] pixel_level
   input  logic        req_tuser,   // op
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [3:0] clean_level, [10:4] glyph_code
   output logic        rsp_tuser,   // row_end
   output logic        rsp_tlast,   // frame_end
   input  logic        csr_wr_en,
   input  logic [6:0]  csr_wr_data  // columns_in_use
);
   import spkrm_pkg::*;

   localparam int unsigned AddrW = $clog2(MaxColumns);
   localparam int unsigned CntColW = $clog2(MaxColumns + 1);
   localparam int unsigned CmpW = (CntColW > ColsW) ? CntColW : ColsW;

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_READ = 3'b010,
      S_CALC = 3'b100
   } state_type;

   state_type         state_ff, state_in;
   logic [ColsW-1:0]  cols_ff;
   logic [AddrW-1:0]  col_ff, col_in;
   level_type         left_ff, left_in;
   logic              row_buf_ff, row_buf_in;
   logic              top_row_ff, top_row_in;
   logic              op_ff;
   level_type         pix_ff;
   logic              last_ff;
   level_type         centre_ff;
   level_type         up_ff;
   logic              rsp_tvalid_ff, rsp_tvalid_in;
   level_type         rsp_level_ff;
   logic              rsp_row_end_ff;
   logic              rsp_frame_end_ff;

   logic [CmpW-1:0]   cols_ext;
   logic [CmpW-1:0]   act_cols;
   logic [CmpW:0]     col_next_ext;
   logic              last;
   logic              accept;
   level_type         pix_clamp;
   logic              go;
   logic              commit;

   logic              raw_we;
   level_type         raw_wdata;
   logic [AddrW-1:0]  raw_raddr;
   level_type         raw_rdata;
   level_type         cln_rdata;
   spkrm_nbr_type     nbr;
   level_type         clean_level;

   assign cols_ext     = CmpW'(cols_ff);
   assign act_cols     = (cols_ff == '0) ? CmpW'(1)
                       : (cols_ext > CmpW'(MaxColumns)) ? CmpW'(MaxColumns) : cols_ext;
   assign col_next_ext = (CmpW+1)'(col_ff) + 1'b1;
   assign last         = col_next_ext >= (CmpW+1)'(act_cols);

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign pix_clamp  = (req_tdata[3:0] > TopLevel) ? TopLevel : req_tdata[3:0];
   assign go         = !rsp_tvalid_ff || rsp_tready;
   assign commit     = (state_ff == S_CALC) && go;

   assign raw_we    = (accept && req_tuser == OpPixel && !row_buf_ff) ||
                      (commit && op_ff == OpPixel);
   assign raw_wdata = (state_ff == S_IDLE) ? pix_clamp : pix_ff;
   assign raw_raddr = (state_ff == S_IDLE) ? col_ff : AddrW'(col_next_ext);

   spkrm_line_store #(
      .MaxColumns (MaxColumns)
   ) u_line_store (
      .clock     (clock),
      .raw_we    (raw_we),
      .raw_waddr (col_ff),
      .raw_wdata (raw_wdata),
      .raw_raddr (raw_raddr),
      .raw_rdata (raw_rdata),
      .cln_we    (commit),
      .cln_addr  (col_ff),
      .cln_wdata (clean_level),
      .cln_rdata (cln_rdata)
   );

   always_comb begin
      nbr.centre    = centre_ff;
      nbr.right     = raw_rdata;
      nbr.down      = pix_ff;
      nbr.left      = left_ff;
      nbr.up        = up_ff;
      nbr.has_right = !last_ff;
      nbr.has_down  = (op_ff == OpPixel);
      nbr.has_left  = (col_ff != '0);
      nbr.has_up    = !top_row_ff;
   end

   spkrm_clean_calc u_clean_calc (
      .nbr   (nbr),
      .level (clean_level)
   );

   always_comb begin
      state_in      = state_ff;
      col_in        = col_ff;
      left_in       = left_ff;
      row_buf_in    = row_buf_ff;
      top_row_in    = top_row_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (!row_buf_ff) begin
                  if (req_tuser == OpPixel) begin
                     if (last) begin
                        col_in     = '0;
                        row_buf_in = 1'b1;
                     end else begin
                        col_in = AddrW'(col_next_ext);
                     end
                  end
               end else begin
                  state_in = S_READ;
               end
            end
         end
         S_READ: begin
            state_in = S_CALC;
         end
         S_CALC: begin
            if (go) begin
               state_in      = S_IDLE;
               rsp_tvalid_in = 1'b1;
               if (last_ff) begin
                  col_in  = '0;
                  left_in = '0;
                  if (op_ff == OpDrain) begin
                     row_buf_in = 1'b0;
                     top_row_in = 1'b1;
                  end else begin
                     top_row_in = 1'b0;
                  end
               end else begin
                  col_in  = AddrW'(col_next_ext);
                  left_in = clean_level;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         cols_ff       <= ColsReset;
         col_ff        <= '0;
         left_ff       <= '0;
         row_buf_ff    <= 1'b0;
         top_row_ff    <= 1'b1;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         col_ff        <= col_in;
         left_ff       <= left_in;
         row_buf_ff    <= row_buf_in;
         top_row_ff    <= top_row_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         if (csr_wr_en) begin
            cols_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff   <= req_tuser;
         pix_ff  <= pix_clamp;
         last_ff <= last;
      end
      if (state_ff == S_READ) begin
         centre_ff <= raw_rdata;
         up_ff     <= cln_rdata;
      end
      if (commit) begin
         rsp_level_ff     <= clean_level;
         rsp_row_end_ff   <= last_ff;
         rsp_frame_end_ff <= last_ff && (op_ff == OpDrain);
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {5'd0, glyph_of(rsp_level_ff), rsp_level_ff};
   assign rsp_tuser  = rsp_row_end_ff;
   assign rsp_tlast  = rsp_frame_end_ff;

endmodule
